>>> rtl/gps_pkg.sv
// shared types and constants for the goldbach pair search block
package gps_pkg;

  localparam int TARGET_W = 17;
  localparam int PRIME_W  = 16;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_SIEVE_RD,
    ST_SIEVE_TEST,
    ST_CROSS,
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } gps_state_t;

endpackage

>>> rtl/gps_flag_ram.sv
// odd-prime flag memory, one write port and two registered read ports
module gps_flag_ram import gps_pkg::*; #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic          rd_data_a,
  output logic          rd_data_b
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> rtl/goldbach_pair_search.sv
// top level of the goldbach pair search block: sieve build and two-pointer search
//
//   channel  direction  handshake                   payload
//   item     in         item_valid / item_stall     target[16:0]
//   result   out        result_valid / result_stall found, low_prime[15:0], high_prime[15:0]
//
// after reset the (PRIME_LIMIT+1)/2 entries of the flag memory are filled, one entry per cycle,
// then sieved: one read and one test per odd base, plus one write per crossed-out multiple;
// item_stall stays high until the sieve is done
// a search accepts the target, walks the low candidate down from n/2, drains the
// last memory read, and then hands over the result
// the pace is one candidate pair per cycle, set by the two read ports of the flag memory
// a finished result waits in the output register; a new transaction can be taken meanwhile
// a stalled result holds the search in its done state until the output register is free
module goldbach_pair_search import gps_pkg::*; #(
  parameter int PRIME_LIMIT = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [TARGET_W-1:0] target,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                found,
  output logic [PRIME_W-1:0]  low_prime,
  output logic [PRIME_W-1:0]  high_prime
);

  // flag store geometry
  localparam int FLAG_DEPTH = (PRIME_LIMIT + 1) / 2;
  localparam int AW = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;
  // sieve value widths: base i and running multiple m
  localparam int KW = $clog2(PRIME_LIMIT);
  localparam int IW = (KW + 1) / 2 + 2;
  localparam int VW = KW + 2;
  localparam int SW = 2 * IW;
  // compare and half-address widths for search values
  localparam int CW = (VW > TARGET_W + 1) ? VW : TARGET_W + 1;
  localparam int HW = (AW > TARGET_W) ? AW : TARGET_W;

  localparam logic [AW-1:0] FILL_LAST = AW'(FLAG_DEPTH - 1);
  localparam logic [CW-1:0] LIMIT_C = CW'(PRIME_LIMIT);
  localparam logic [VW-1:0] LIMIT_V = VW'(PRIME_LIMIT);
  localparam logic [SW-1:0] LIMIT_S = SW'(PRIME_LIMIT);
  localparam logic [PRIME_W-1:0] LOW_MIN = PRIME_W'(3);

  gps_state_t state, state_next;

  // sieve registers
  logic [AW-1:0] fill_addr;
  logic [IW-1:0] base;
  logic [VW-1:0] mult;
  logic          sq_big;

  // search registers
  logic [TARGET_W-1:0] n;
  logic [PRIME_W-1:0]  p;
  logic                s1_valid;
  logic                s1_ok;
  logic [PRIME_W-1:0]  s1_p;
  logic [TARGET_W-1:0] s1_q;

  // finished result waiting for the output register
  logic                res_found;
  logic [PRIME_W-1:0]  res_lo;
  logic [TARGET_W-1:0] res_hi;

  // memory port signals
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic          rd_data_a;
  logic          rd_data_b;

  // datapath helpers
  logic [SW-1:0]       sq;
  logic [VW-1:0]       mult_step;
  logic                mult_end;
  logic [TARGET_W-1:0] q;
  logic                p_ok;
  logic                q_ok;
  logic                p_more;
  logic                hit;
  logic                out_free;
  logic [HW-1:0]       base_half;
  logic [HW-1:0]       p_half;
  logic [HW-1:0]       q_half;
  logic [PRIME_W-1:0]  half_n;
  logic [PRIME_W-1:0]  p_start;

  gps_flag_ram #(
    .DEPTH(FLAG_DEPTH),
    .AW   (AW)
  ) u_flags (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  // sieve arithmetic
  assign sq        = SW'(base) * SW'(base);
  assign mult_step = mult + (VW'(base) << 1);
  assign mult_end  = (mult_step >= LIMIT_V);

  // search arithmetic: high candidate and range checks
  assign q      = n - TARGET_W'(p);
  assign p_ok   = (CW'(p) < LIMIT_C);
  assign q_ok   = q[0] && (CW'(q) < LIMIT_C);
  assign p_more = (p >= LOW_MIN);
  // pair issued last cycle, flags now out of the memory
  assign hit    = s1_valid && s1_ok && rd_data_a && rd_data_b;

  assign base_half = HW'(base >> 1);
  assign p_half    = HW'(p >> 1);
  assign q_half    = HW'(q >> 1);

  // largest odd value at or below n/2, or 1 when there is none
  assign half_n  = target[TARGET_W-1:1];
  assign p_start = half_n[0] ? half_n :
                   ((half_n == '0) ? PRIME_W'(1) : half_n - PRIME_W'(1));

  assign out_free = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL: begin
        if (fill_addr == FILL_LAST) begin
          state_next = ST_SIEVE_RD;
        end
      end
      ST_SIEVE_RD: begin
        state_next = ST_SIEVE_TEST;
      end
      ST_SIEVE_TEST: begin
        if (sq_big) begin
          state_next = ST_IDLE;
        end else if (!rd_data_a) begin
          state_next = ST_SIEVE_RD;
        end else begin
          state_next = ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (mult_end) begin
          state_next = ST_SIEVE_RD;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit || !p_more) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  // memory controls and input handshake
  always_comb begin
    item_stall = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = fill_addr;
    wr_data    = 1'b0;
    rd_addr_a  = p_half[AW-1:0];
    rd_addr_b  = q_half[AW-1:0];
    case (state)
      ST_FILL: begin
        // every odd value starts as a candidate prime, except 1
        wr_en   = 1'b1;
        wr_addr = fill_addr;
        wr_data = (fill_addr != '0);
      end
      ST_SIEVE_RD: begin
        rd_addr_a = base_half[AW-1:0];
      end
      ST_CROSS: begin
        wr_en   = 1'b1;
        wr_addr = mult[AW:1];
        wr_data = 1'b0;
      end
      ST_IDLE: begin
        item_stall = 1'b0;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // sieve control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
      base      <= IW'(3);
      sq_big    <= 1'b0;
    end else begin
      case (state)
        ST_FILL: begin
          fill_addr <= fill_addr + AW'(1);
        end
        ST_SIEVE_RD: begin
          sq_big <= (sq >= LIMIT_S);
        end
        ST_SIEVE_TEST: begin
          if (!sq_big && !rd_data_a) begin
            base <= base + IW'(2);
          end
        end
        ST_CROSS: begin
          if (mult_end) begin
            base <= base + IW'(2);
          end
        end
        default: begin
          base <= base;
        end
      endcase
    end
  end

  // running multiple, starts at base squared
  always_ff @(posedge clk) begin
    if (state == ST_SIEVE_RD) begin
      mult <= sq[VW-1:0];
    end else if (state == ST_CROSS) begin
      mult <= mult_step;
    end
  end

  // search walk: issue one low/high pair per cycle, test it the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (state == ST_IDLE) begin
      s1_valid <= 1'b0;
    end else if (state == ST_SEARCH) begin
      s1_valid <= p_more;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      n <= target;
      p <= p_start;
    end else if (state == ST_SEARCH) begin
      s1_p  <= p;
      s1_q  <= q;
      s1_ok <= p_ok && q_ok;
      if (p_more) begin
        p <= p - PRIME_W'(2);
      end
    end
  end

  // capture the outcome of the walk
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH) begin
      if (hit) begin
        res_found <= 1'b1;
        res_lo    <= s1_p;
        res_hi    <= s1_q;
      end else begin
        res_found <= 1'b0;
        res_lo    <= '0;
        res_hi    <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      found      <= res_found;
      low_prime  <= res_lo;
      high_prime <= res_hi[PRIME_W-1:0];
    end
  end

  // a reported pair adds up to the target and keeps the low prime on the low side
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_found) |->
      ((TARGET_W'(res_lo) + res_hi) == n && TARGET_W'(res_lo) <= res_hi))
    else $error("pair does not split the target");

  // a failed search reports zero primes
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (low_prime == '0 && high_prime == '0))
    else $error("failure result carries nonzero primes");

  // both primes of a reported pair are odd
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && found) |-> (low_prime[0] && high_prime[0]))
    else $error("reported prime is even");

  // a taken transaction starts the walk at once
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == ST_SEARCH && !s1_valid))
    else $error("search did not start after accept");

endmodule
